@@ sv/ps2dlc_pkg.sv @@
//------------------------------------------------------------------------------
// ps2dlc_pkg
// Shared types and constants of the PS/2 device-side link controller.
//------------------------------------------------------------------------------
`default_nettype none
package ps2dlc_pkg;
	localparam int QueueDepth = 16;
	localparam int QIdxW = $clog2(QueueDepth);
	localparam int QCntW = $clog2(QueueDepth + 1);

	typedef enum logic [2:0] {
		ACT_TICK = 3'd0, ACT_ENQ = 3'd1, ACT_CLEAR = 3'd2, ACT_RESEND = 3'd3,
		ACT_CLR_ERR = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		ERR_NONE = 3'd0, ERR_INHIBIT = 3'd1, ERR_START = 3'd2, ERR_STOP = 3'd3,
		ERR_PARITY = 3'd4, ERR_OVERFLOW = 3'd5
	} err_t;

	typedef enum logic [3:0] {
		PH_IDLE, PH_WAIT, PH_TX_SETUP, PH_TX_LOW, PH_TX_POST, PH_TX_TAIL,
		PH_RX_START, PH_RX_LOW, PH_RX_SETTLE, PH_RX_POST,
		PH_ACK_SETUP, PH_ACK_LOW, PH_ACK_HOLD
	} phase_t;

	typedef enum logic [2:0] {
		REG_SETUP = 3'd0, REG_PULSE = 3'd1, REG_POST = 3'd2, REG_IDLE = 3'd3,
		REG_TIMEOUT = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] setup_ticks;
		logic [7:0] pulse_ticks;
		logic [7:0] post_pulse_ticks;
		logic [7:0] idle_ticks;
		logic [7:0] ready_timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic       clk_drive_low;
		logic       data_drive_low;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       tx_done;
		logic [2:0] error_code;
		logic [4:0] queue_count;
		logic       link_busy;
	} result_t;

	function automatic logic [7:0] dur(input logic [7:0] t);
		return (t == 8'd0) ? 8'd1 : t;
	endfunction
endpackage
`default_nettype wire

@@ sv/ps2_device_link_controller_top.sv @@
//------------------------------------------------------------------------------
// ps2_device_link_controller_top
// PS/2 device-side link controller with byte queue and APB timing registers.
//------------------------------------------------------------------------------
// Each beat (a 1 us tick with sampled line levels, or a command) gives one
// result beat, registered once the output is free; a new beat is taken every
// cycle unless the output stalls. The queue read is a registered RAM port whose
// address follows the state of the next beat, so the one-pass update never waits.
`default_nettype none
module ps2_device_link_controller_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [2:0] action, [10:3] byte_in, [11] clk_line_high, [12] data_line_high
	input  wire logic [15:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [0] clk_drive_low, [1] data_drive_low, [2] rx_valid, [10:3] rx_byte,
	// [11] tx_done, [14:12] error_code, [19:15] queue_count, [20] link_busy
	output logic      [23:0] m_tdata,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	import ps2dlc_pkg::*;

	cfg_t       cfg;
	result_t    res;
	logic       vld_s1, ovld_q, acc, q_we;
	logic [15:0] dat_s1;
	logic [7:0] qrd;
	logic [QIdxW-1:0] q_waddr, q_raddr;

	assign pready   = 1'b1;
	assign s_tready = !vld_s1 || !ovld_q || m_tready;
	assign acc      = s_tvalid && s_tready;
	assign m_tvalid = ovld_q;

	ps2dlc_cfg u_cfg (.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .cfg);

	ps2dlc_ram #(.Width(8), .Depth(QueueDepth)) u_ram (.clk, .we(q_we), .waddr(q_waddr),
		.wdata(dat_s1[10:3]), .raddr(q_raddr), .rdata(qrd));

	ps2dlc_core u_core (.clk, .arst_n, .cfg, .item_vld_s1(vld_s1 && (!ovld_q || m_tready)),
		.action_s1(dat_s1[2:0]), .byte_s1(dat_s1[10:3]), .clk_s1(dat_s1[11]),
		.dat_s1(dat_s1[12]), .qrd_data(qrd), .q_we, .q_waddr, .q_raddr, .res);

	logic adv;
	assign adv = vld_s1 && (!ovld_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			ovld_q <= 1'b0;
		end else begin
			if (acc) vld_s1 <= 1'b1;
			else if (adv) vld_s1 <= 1'b0;
			if (adv) ovld_q <= 1'b1;
			else if (m_tready) ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) dat_s1 <= s_tdata;
		if (adv) m_tdata <= {3'd0, res.link_busy, res.queue_count, res.error_code,
			res.tx_done, res.rx_byte, res.rx_valid, res.data_drive_low, res.clk_drive_low};
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && ovld_q && !m_tready |-> !s_tready) else $error("overrun");
	a_adv: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_tvalid) else $error("lost result");
endmodule
`default_nettype wire

@@ sv/ps2dlc_ram.sv @@
//------------------------------------------------------------------------------
// ps2dlc_ram
// Generic single-port-write RAM with registered read.
//------------------------------------------------------------------------------
`default_nettype none
module ps2dlc_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ sv/ps2dlc_cfg.sv @@
//------------------------------------------------------------------------------
// ps2dlc_cfg
// APB register file holding the timing registers.
//------------------------------------------------------------------------------
`default_nettype none
module ps2dlc_cfg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [4:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output ps2dlc_pkg::cfg_t       cfg
);
	import ps2dlc_pkg::*;

	cfg_t cfg_q;
	logic [2:0] idx;
	logic wr;

	assign idx = paddr[4:2];
	assign wr  = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{8'd15, 8'd39, 8'd22, 8'd50, 8'd200};
		end else if (wr) begin
			unique case (idx)
				REG_SETUP:   cfg_q.setup_ticks         <= pwdata[7:0];
				REG_PULSE:   cfg_q.pulse_ticks         <= pwdata[7:0];
				REG_POST:    cfg_q.post_pulse_ticks    <= pwdata[7:0];
				REG_IDLE:    cfg_q.idle_ticks          <= pwdata[7:0];
				REG_TIMEOUT: cfg_q.ready_timeout_ticks <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_SETUP:   prdata = {24'd0, cfg_q.setup_ticks};
			REG_PULSE:   prdata = {24'd0, cfg_q.pulse_ticks};
			REG_POST:    prdata = {24'd0, cfg_q.post_pulse_ticks};
			REG_IDLE:    prdata = {24'd0, cfg_q.idle_ticks};
			REG_TIMEOUT: prdata = {24'd0, cfg_q.ready_timeout_ticks};
			default:     prdata = 32'd0;
		endcase
	end
endmodule
`default_nettype wire

@@ sv/ps2dlc_core.sv @@
//------------------------------------------------------------------------------
// ps2dlc_core
// Link state, queue pointers and one-pass update per registered item.
//------------------------------------------------------------------------------
`default_nettype none
module ps2dlc_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ps2dlc_pkg::cfg_t    cfg,
	input  wire logic                item_vld_s1,
	input  wire logic [2:0]          action_s1,
	input  wire logic [7:0]          byte_s1,
	input  wire logic                clk_s1,
	input  wire logic                dat_s1,
	input  wire logic [7:0]          qrd_data,
	output logic                     q_we,
	output logic [ps2dlc_pkg::QIdxW-1:0] q_waddr,
	output logic [ps2dlc_pkg::QIdxW-1:0] q_raddr,
	output ps2dlc_pkg::result_t      res
);
	import ps2dlc_pkg::*;

	phase_t     ph_q, ph_d;
	logic [7:0] tmr_q, tmr_d, run_q, run_d, wl_q, wl_d, sh_q, sh_d;
	logic [3:0] bi_q, bi_d;
	logic       par_q, par_d, rsp_q, rsp_d, isr_q, isr_d, dc_q, dc_d, dd_q, dd_d;
	logic [2:0] err_q, err_d;
	logic [QIdxW-1:0] hd_q, hd_d, tl_q, tl_d;
	logic [QCntW-1:0] cnt_q, cnt_d;
	logic       rxv, txd, timed, begin_tx, rsp_rd;
	logic [7:0] rxb, run_inc;
	logic       byp_q;
	logic [7:0] byp_dat_q, q_rd;

	// Read address tracks the state the next item will see.
	assign rsp_rd  = rsp_d;
	assign q_raddr = rsp_rd ? (hd_d - 1'b1) : tl_d;
	assign q_we    = item_vld_s1 && action_s1 == ACT_ENQ && cnt_q < QCntW'(QueueDepth);
	assign q_waddr = hd_q;
	assign timed   = ph_q >= PH_TX_SETUP;
	assign run_inc = (run_q < 8'd255) ? run_q + 8'd1 : run_q;
	// Forward a byte written at the same edge its slot was read.
	assign q_rd    = byp_q ? byp_dat_q : qrd_data;

	function automatic logic tx_bit(input logic [3:0] b, input logic [7:0] s, input logic p);
		if (b == 4'd0) return 1'b0;
		else if (b <= 4'd8) return s[3'(b - 4'd1)];
		else if (b == 4'd9) return ~p;
		else return 1'b1;
	endfunction

	always_comb begin
		ph_d = ph_q; tmr_d = tmr_q; run_d = run_q; wl_d = wl_q; sh_d = sh_q;
		bi_d = bi_q; par_d = par_q; rsp_d = rsp_q; isr_d = isr_q;
		dc_d = dc_q; dd_d = dd_q; err_d = err_q; hd_d = hd_q; tl_d = tl_q;
		cnt_d = cnt_q; rxv = 1'b0; rxb = 8'd0; txd = 1'b0; begin_tx = 1'b0;
		if (item_vld_s1) begin
			unique case (action_s1)
				ACT_TICK: begin
					if (timed && tmr_q > 8'd1) begin
						tmr_d = tmr_q - 8'd1;
					end else begin
						if (timed) tmr_d = 8'd0;
						unique case (ph_q)
							PH_IDLE: begin
								if (clk_s1 && !dat_s1) begin
									sh_d = 8'd0; par_d = 1'b0; ph_d = PH_RX_START;
									tmr_d = dur(cfg.setup_ticks);
								end else if (rsp_q || cnt_q != '0) begin
									ph_d = PH_WAIT; wl_d = cfg.ready_timeout_ticks; run_d = 8'd0;
								end
							end
							PH_WAIT: begin
								if (clk_s1 && !dat_s1) begin
									run_d = 8'd0; sh_d = 8'd0; par_d = 1'b0;
									ph_d = PH_RX_START; tmr_d = dur(cfg.setup_ticks);
								end else if (wl_q == 8'd0) begin
									ph_d = PH_IDLE; rsp_d = 1'b0;
								end else begin
									wl_d = wl_q - 8'd1;
									if (clk_s1 && dat_s1) begin
										run_d = run_inc;
										if (run_inc >= dur(cfg.idle_ticks)) begin_tx = 1'b1;
									end else begin
										run_d = 8'd0;
										if (wl_d < cfg.idle_ticks) begin
											ph_d = PH_IDLE; rsp_d = 1'b0;
										end
									end
								end
							end
							PH_TX_SETUP: begin
								dc_d = 1'b1; ph_d = PH_TX_LOW; tmr_d = dur(cfg.pulse_ticks);
							end
							PH_TX_LOW: begin
								dc_d = 1'b0; ph_d = PH_TX_POST; tmr_d = dur(cfg.post_pulse_ticks);
							end
							PH_TX_POST: begin
								if (bi_q >= 4'd10) begin
									ph_d = PH_TX_TAIL; tmr_d = dur(cfg.setup_ticks);
								end else if (!clk_s1) begin
									err_d = ERR_INHIBIT; ph_d = PH_IDLE; dc_d = 1'b0; dd_d = 1'b0;
									if (isr_q) rsp_d = 1'b0;
								end else begin
									bi_d = bi_q + 4'd1;
									dd_d = ~tx_bit(bi_d, sh_q, par_q);
									ph_d = PH_TX_SETUP; tmr_d = dur(cfg.setup_ticks);
								end
							end
							PH_TX_TAIL: begin
								ph_d = PH_IDLE; dc_d = 1'b0; dd_d = 1'b0;
								if (isr_q) rsp_d = 1'b0;
								if (!isr_q && cnt_q != '0) begin
									tl_d = tl_q + 1'b1; cnt_d = cnt_q - 1'b1; txd = 1'b1;
								end
							end
							PH_RX_START: begin
								if (dat_s1) begin
									err_d = ERR_START; ph_d = PH_IDLE; dc_d = 1'b0; dd_d = 1'b0;
								end else begin
									bi_d = 4'd0; dc_d = 1'b1; ph_d = PH_RX_LOW;
									tmr_d = dur(cfg.pulse_ticks);
								end
							end
							PH_RX_LOW: begin
								dc_d = 1'b0;
								if (bi_q > 4'd8 && !dat_s1) begin
									err_d = ERR_STOP; ph_d = PH_IDLE; dd_d = 1'b0;
								end else begin
									if (bi_q < 4'd8) sh_d = {dat_s1, sh_q[7:1]};
									if (bi_q <= 4'd8) par_d = par_q ^ dat_s1;
									if (bi_q < 4'd9) begin
										ph_d = PH_RX_SETTLE; tmr_d = dur(cfg.setup_ticks);
									end else begin
										ph_d = PH_RX_POST; tmr_d = dur(cfg.post_pulse_ticks);
									end
								end
							end
							PH_RX_SETTLE: begin
								ph_d = PH_RX_POST; tmr_d = dur(cfg.post_pulse_ticks);
							end
							PH_RX_POST: begin
								if (!clk_s1) begin
									err_d = ERR_INHIBIT; ph_d = PH_IDLE; dc_d = 1'b0; dd_d = 1'b0;
								end else if (bi_q < 4'd9) begin
									bi_d = bi_q + 4'd1; dc_d = 1'b1; ph_d = PH_RX_LOW;
									tmr_d = dur(cfg.pulse_ticks);
								end else if (!par_q) begin
									err_d = ERR_PARITY; ph_d = PH_IDLE; dc_d = 1'b0; dd_d = 1'b0;
								end else begin
									dd_d = 1'b1; ph_d = PH_ACK_SETUP; tmr_d = dur(cfg.setup_ticks);
								end
							end
							PH_ACK_SETUP: begin
								dc_d = 1'b1; ph_d = PH_ACK_LOW; tmr_d = dur(cfg.pulse_ticks);
							end
							PH_ACK_LOW: begin
								dc_d = 1'b0; ph_d = PH_ACK_HOLD; tmr_d = dur(cfg.pulse_ticks);
							end
							PH_ACK_HOLD: begin
								ph_d = PH_IDLE; dc_d = 1'b0; dd_d = 1'b0; rxv = 1'b1; rxb = sh_q;
							end
							default: begin
								ph_d = PH_IDLE; dc_d = 1'b0; dd_d = 1'b0;
							end
						endcase
					end
					if (begin_tx) begin
						isr_d = rsp_q; sh_d = q_rd; par_d = ^q_rd; bi_d = 4'd0;
						dd_d = 1'b1; ph_d = PH_TX_SETUP; tmr_d = dur(cfg.setup_ticks);
					end
				end
				ACT_ENQ: begin
					if (cnt_q >= QCntW'(QueueDepth)) err_d = ERR_OVERFLOW;
					else begin
						hd_d = hd_q + 1'b1; cnt_d = cnt_q + 1'b1;
					end
				end
				ACT_CLEAR:   begin hd_d = tl_q; cnt_d = '0; end
				ACT_RESEND:  rsp_d = 1'b1;
				ACT_CLR_ERR: err_d = ERR_NONE;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE; tmr_q <= '0; run_q <= '0; wl_q <= '0; sh_q <= '0; bi_q <= '0;
			par_q <= 1'b0; rsp_q <= 1'b0; isr_q <= 1'b0; dc_q <= 1'b0; dd_q <= 1'b0;
			err_q <= ERR_NONE; hd_q <= '0; tl_q <= '0; cnt_q <= '0;
			byp_q <= 1'b0; byp_dat_q <= '0;
		end else begin
			ph_q <= ph_d; tmr_q <= tmr_d; run_q <= run_d; wl_q <= wl_d; sh_q <= sh_d;
			bi_q <= bi_d; par_q <= par_d; rsp_q <= rsp_d; isr_q <= isr_d; dc_q <= dc_d;
			dd_q <= dd_d; err_q <= err_d; hd_q <= hd_d; tl_q <= tl_d; cnt_q <= cnt_d;
			byp_q <= q_we && q_waddr == q_raddr;
			if (q_we) byp_dat_q <= byte_s1;
		end
	end

	always_comb begin
		res.clk_drive_low  = dc_d;
		res.data_drive_low = dd_d;
		res.rx_valid       = rxv;
		res.rx_byte        = rxb;
		res.tx_done        = txd;
		res.error_code     = err_d;
		res.queue_count    = 5'(cnt_d);
		res.link_busy      = ph_d != PH_IDLE && ph_d != PH_WAIT;
	end

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCntW'(QueueDepth)) else $error("queue count overrun");
	a_txd_pop: assert property (@(posedge clk) disable iff (!arst_n)
		txd |=> cnt_q == $past(cnt_q) - 1'b1) else $error("tx_done without pop");
	a_rxv_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rxv |=> ph_q == PH_IDLE) else $error("rx_valid outside idle return");
endmodule
`default_nettype wire
